// ----- rtl/core/sfir_pkg.sv -----
// Shared types, constants and coefficient lookup for the symmetric FIR filter unit.
// Used by sfir_ctrl, sfir_datapath and symmetric_fir_filter_unit. No dependencies.
`default_nettype none

package sfir_pkg;

   localparam int SET_IDX_W  = 6;
   localparam int LP_TAPS    = 34;
   localparam int FAN_TAPS   = 36;
   localparam int LP_HALF_N  = 17;
   localparam int FAN_HALF_N = 18;
   localparam int Q21_W      = 24;

   // first half of each symmetric set, Q2.21
   localparam logic signed [Q21_W-1:0] LP_HALF [LP_HALF_N] = '{
      24'sd54946,   24'sd133640,  -24'sd74148,  -24'sd27732,  -24'sd51620,
      -24'sd15367,  24'sd28543,   24'sd65491,   24'sd61212,   24'sd8735,
      -24'sd68122,  -24'sd119102, -24'sd93544,  24'sd30141,   24'sd225372,
      24'sd425573,  24'sd551654
   };

   localparam logic signed [Q21_W-1:0] FAN_HALF [FAN_HALF_N] = '{
      -24'sd2116532, 24'sd744271,   24'sd175066,  24'sd93186,   -24'sd66210,
      24'sd68244,    -24'sd50118,   24'sd18653,   -24'sd81965,  24'sd66620,
      -24'sd139036,  24'sd98802,    -24'sd134249, 24'sd131531,  -24'sd184556,
      24'sd296448,   -24'sd419180,  24'sd1271951
   };

   typedef struct packed {
      logic signed [15:0] sample_in;
      logic               block_start;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               passed_through;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic                 load;
      logic                 mac;
      logic                 first;
      logic [SET_IDX_W-1:0] idx;
      logic                 finish;
   } cmd_type;

   // Q2.21 coefficient of tap j, mirrored about the set center
   function automatic logic signed [Q21_W-1:0] coef_q21(input logic sel,
                                                        input logic [SET_IDX_W-1:0] j);
      logic [SET_IDX_W-1:0]     len;
      logic [SET_IDX_W-1:0]     k;
      logic signed [Q21_W-1:0]  q;
      len = sel ? SET_IDX_W'(FAN_TAPS) : SET_IDX_W'(LP_TAPS);
      k   = (j < (len >> 1)) ? j : (len - SET_IDX_W'(1) - j);
      q   = '0;
      if (sel) begin
         if (k < SET_IDX_W'(FAN_HALF_N)) q = FAN_HALF[k[4:0]];
      end else begin
         if (k < SET_IDX_W'(LP_HALF_N)) q = LP_HALF[k[4:0]];
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sfir_ctrl.sv -----
// Controller state machine of the symmetric FIR filter unit: sequences the taps
// and owns the handshakes. Depends on sfir_pkg.
`default_nettype none

module sfir_ctrl
   import sfir_pkg::*;
#(
   parameter int MAX_TAPS = 36
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd
);

   localparam int STEP_W = $clog2(MAX_TAPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_TAPS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MAC    = 3'd1;
   localparam logic [2:0] ST_DRAIN1 = 3'd2;
   localparam logic [2:0] ST_DRAIN2 = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.idx      = SET_IDX_W'(step_ff);
      cmd.first    = (step_ff == '0);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mac = 1'b1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) state_in = ST_DRAIN1;
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sfir_datapath.sv -----
// Datapath of the symmetric FIR filter unit: rotating delay line, coefficient and
// multiply stages, accumulator, rounding/saturation and result register. Depends on sfir_pkg.
`default_nettype none

module sfir_datapath
   import sfir_pkg::*;
#(
   parameter int MAX_TAPS   = 36,
   parameter int COEF_WIDTH = 18
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire logic    filter_select,
   input  wire cmd_type cmd,
   output rsp_type      rsp_data
);

   localparam int DEPTH     = MAX_TAPS - 1;
   localparam int WARM_W    = $clog2(MAX_TAPS);
   localparam int FRAC_BITS = COEF_WIDTH - 3;
   localparam int COEF_SH   = Q21_W - COEF_WIDTH;
   localparam int COEF_HALF = (COEF_SH > 0) ? (1 << (COEF_SH - 1)) : 0;
   localparam int PROD_W    = COEF_WIDTH + 16;
   localparam int ACC_W     = PROD_W + $clog2(MAX_TAPS) + 1;
   localparam int TAPS_LP   = (MAX_TAPS < LP_TAPS) ? MAX_TAPS : LP_TAPS;
   localparam int TAPS_FAN  = (MAX_TAPS < FAN_TAPS) ? MAX_TAPS : FAN_TAPS;

   localparam logic [WARM_W-1:0]       WARM_MAX   = WARM_W'(MAX_TAPS - 1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] Y_MAX      = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] Y_MIN      = ~Y_MAX;

   logic signed [15:0]           delay_ff [DEPTH];
   logic [WARM_W-1:0]            warm_ff;
   logic                         v1_ff, v2_ff;
   logic signed [15:0]           x_ff;
   logic                         pass_ff;
   logic signed [COEF_WIDTH-1:0] coef_ff;
   logic signed [15:0]           oper_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   rsp_type                      rsp_ff;

   logic [WARM_W-1:0]            warm_eff;
   logic [WARM_W-1:0]            taps_m1;
   logic [SET_IDX_W-1:0]         taps_sel;
   logic signed [Q21_W-1:0]      coef_raw;
   logic signed [Q21_W:0]        coef_sum;
   logic signed [COEF_WIDTH-1:0] coef_in;
   logic signed [ACC_W-1:0]      round_sum;
   logic signed [ACC_W-1:0]      round_q;
   rsp_type                      rsp_in;

   assign warm_eff = req_data.block_start ? '0 : warm_ff;
   assign taps_m1  = filter_select ? WARM_W'(TAPS_FAN - 1) : WARM_W'(TAPS_LP - 1);
   assign taps_sel = filter_select ? SET_IDX_W'(TAPS_FAN) : SET_IDX_W'(TAPS_LP);

   always_comb begin
      coef_raw = coef_q21(filter_select, cmd.idx);
      coef_sum = {coef_raw[Q21_W-1], coef_raw} + (Q21_W+1)'(COEF_HALF);
      coef_in  = (cmd.idx < taps_sel) ? COEF_WIDTH'(coef_sum >>> COEF_SH) : '0;
   end

   always_comb begin
      round_sum = acc_ff + ROUND_HALF;
      round_q   = round_sum >>> FRAC_BITS;
      rsp_in.passed_through = pass_ff;
      rsp_in.saturated      = 1'b0;
      rsp_in.sample_out     = round_q[15:0];
      if (pass_ff) begin
         rsp_in.sample_out = x_ff;
      end else if (round_q > Y_MAX) begin
         rsp_in.sample_out = 16'sh7FFF;
         rsp_in.saturated  = 1'b1;
      end else if (round_q < Y_MIN) begin
         rsp_in.sample_out = 16'sh8000;
         rsp_in.saturated  = 1'b1;
      end
   end

   // state with reset values: delay line, warm-up count, stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) delay_ff[k] <= '0;
         warm_ff <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
      end else begin
         v1_ff <= cmd.mac;
         v2_ff <= v1_ff;
         if (cmd.load) warm_ff <= warm_eff;
         if (cmd.mac && !cmd.first) begin
            // rotate so the next older sample sits at entry 0
            for (int k = 0; k < DEPTH - 1; k++) delay_ff[k] <= delay_ff[k+1];
            delay_ff[DEPTH-1] <= delay_ff[0];
         end
         if (cmd.finish) begin
            for (int k = 1; k < DEPTH; k++) delay_ff[k] <= delay_ff[k-1];
            delay_ff[0] <= x_ff;
            if (warm_ff < WARM_MAX) warm_ff <= warm_ff + WARM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_data.sample_in;
         pass_ff <= (warm_eff < taps_m1);
         acc_ff  <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.mac) begin
         coef_ff <= coef_in;
         oper_ff <= cmd.first ? x_ff : delay_ff[0];
      end
      prod_ff <= coef_ff * oper_ff;
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/symmetric_fir_filter_unit.sv -----
// Top level of the symmetric FIR filter unit: filter_select register, controller
// and datapath. Depends on sfir_pkg, sfir_ctrl and sfir_datapath.
`default_nettype none

// Symmetric FIR filter over signed 16-bit samples, one result per sample. The
// filter_select register picks the 34-tap low-pass set (0) or the 36-tap fan-noise
// set (1); write it only while the unit is idle. One shared multiplier takes one tap
// per cycle over MAX_TAPS steps, followed by the drain states DRAIN1 and DRAIN2 and
// a finish state that waits until the result register is free, then returns to idle
// for the next sample. The result register lets a new sample be taken
// while the previous result waits. After block_start, the first taps-1 samples of
// the block pass through unchanged with passed_through set; saturated flags clipping.

module symmetric_fir_filter_unit
   import sfir_pkg::*;
#(
   parameter int MAX_TAPS   = 36,
   parameter int COEF_WIDTH = 18
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   logic    filter_select_ff;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_select_ff <= 1'b0;
      end else if (csr_valid) begin
         filter_select_ff <= csr_data;
      end
   end

   sfir_ctrl #(
      .MAX_TAPS (MAX_TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sfir_datapath #(
      .MAX_TAPS   (MAX_TAPS),
      .COEF_WIDTH (COEF_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .filter_select (filter_select_ff),
      .cmd           (cmd),
      .rsp_data      (rsp_data)
   );

   a_pass_not_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.passed_through && rsp_data.saturated))
      else $error("pass-through result flagged as saturated");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a transfer");

   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten before transfer");

   a_mac_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mac |-> !req_ready && !cmd.load)
      else $error("tap step while idle");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for symmetric_fir_filter_unit: directed edge samples, then
// random sample blocks under both coefficient sets, checked against a tap-accurate predictor.
// Depends on sfir_pkg (transfer types, coefficient halves) and the DUT only.
`default_nettype none

module testbench;
   import sfir_pkg::*;

   localparam int DELAY_DEPTH  = 35;
   localparam int COEF_SHIFT   = 6;
   localparam int FRAC_BITS    = 15;
   localparam int DRAIN_CYCLES = 60;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 212;
   localparam int RUN_LIMIT    = 2000000;

   localparam logic [15:0] EDGE_SAMPLES [12] = '{
      16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555,
      16'hAAAA, 16'h8000, 16'h7FFF, 16'h7FFE, 16'h8001, 16'h0100
   };
   localparam logic SET_PLAN [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

   class fir_scoreboard;
      logic signed [15:0] history [DELAY_DEPTH];
      int unsigned        warm_count;
      logic               set_sel;
      rsp_type            expected_q [$];
      int                 failures;

      function new();
         foreach (history[k]) history[k] = '0;
         warm_count = 0;
         set_sel    = 1'b0;
         failures   = 0;
      endfunction

      function void select_set(input logic v);
         set_sel = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Q2.15 tap value: Q2.21 half-table entry, mirrored, rounded half up
      function longint tap_coef(input int j);
         int     len;
         int     k;
         longint q;
         len = set_sel ? FAN_TAPS : LP_TAPS;
         k   = (j < len / 2) ? j : (len - 1 - j);
         q   = set_sel ? longint'(FAN_HALF[k]) : longint'(LP_HALF[k]);
         return (q + (longint'(1) << (COEF_SHIFT - 1))) >>> COEF_SHIFT;
      endfunction

      function void note_request(input req_type r);
         logic signed [15:0] x;
         int                 taps;
         int                 j;
         longint             acc;
         longint             y;
         rsp_type            e;
         x    = r.sample_in;
         taps = set_sel ? FAN_TAPS : LP_TAPS;
         if (r.block_start) warm_count = 0;
         e.saturated = 1'b0;
         if (warm_count < taps - 1) begin
            e.sample_out     = x;
            e.passed_through = 1'b1;
         end else begin
            acc = tap_coef(0) * longint'(x);
            for (j = 1; j < taps; j++) acc += tap_coef(j) * longint'(history[j - 1]);
            y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (y > 32767) begin
               y = 32767;
               e.saturated = 1'b1;
            end else if (y < -32768) begin
               y = -32768;
               e.saturated = 1'b1;
            end
            e.sample_out     = y[15:0];
            e.passed_through = 1'b0;
         end
         for (j = DELAY_DEPTH - 1; j > 0; j--) history[j] = history[j - 1];
         history[0] = x;
         if (warm_count < DELAY_DEPTH) warm_count++;
         expected_q.push_back(e);
      endfunction

      function void check_response(input rsp_type r);
         rsp_type e;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: sample_out=%0d passed_through=%0b saturated=%0b",
                        r.sample_out, r.passed_through, r.saturated);
            return;
         end
         e = expected_q.pop_front();
         if (r.sample_out !== e.sample_out || r.passed_through !== e.passed_through ||
             r.saturated !== e.saturated) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b (sample/pass/sat)",
                        e.sample_out, e.passed_through, e.saturated,
                        r.sample_out, r.passed_through, r.saturated);
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   fir_scoreboard sb = new();

   symmetric_fir_filter_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
         if (csr_valid && csr_ready) sb.select_set(csr_data);
      end
   end

   function automatic req_type make_req(input logic [15:0] s, input logic start);
      req_type r;
      r.sample_in   = s;
      r.block_start = start;
      return r;
   endfunction

   function automatic logic [15:0] draw_sample(input int mode, input logic [15:0] level);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 1023)) - 16'd512;
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'($urandom);
            endcase
         end
         default: return level;
      endcase
   endfunction

   task automatic send_sample(input req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_select(input logic v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int          phase;
      int          sent;
      int          len;
      int          mode;
      int          k;
      int          pick;
      logic        first_block;
      logic        start;
      logic [15:0] level;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // stream from reset counts as a block; then a one-sample block and a restart
      foreach (EDGE_SAMPLES[i])
         send_sample(make_req(EDGE_SAMPLES[i], (i == 7 || i == 8 || i == 11)));

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct  = (phase % 4 == 1) ? 62 : (phase % 4 == 3) ? 27 : 0;
         recv_stall_pct = (phase % 4 == 2) ? 62 : (phase % 4 == 3) ? 27 : 0;
         write_select(SET_PLAN[phase]);
         sent        = 0;
         first_block = 1'b1;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 15) len = $urandom_range(1, 40);
            else if (pick < 35) len = $urandom_range(32, 37);
            else len = $urandom_range(38, 100);
            if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
            mode  = $urandom_range(0, 3);
            level = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                    ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            for (k = 0; k < len; k++) begin
               // first block of a phase may carry on under the new set
               if (k == 0) start = first_block ? 1'($urandom_range(0, 1)) : 1'b1;
               else start = ($urandom_range(99) < 2);
               send_sample(make_req(draw_sample(mode, level), start));
            end
            first_block = 1'b0;
            sent += len;
         end
      end

      wait_idle();
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("symmetric_fir_filter_unit verification clean");
      end else begin
         $display("symmetric_fir_filter_unit verification failed");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("symmetric_fir_filter_unit verification failed");
      $finish;
   end

endmodule

`default_nettype wire
